@@ rtl/core/tlpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpc_pkg: shared types and constants
// Request and result payloads, configuration set, light and phase codes,
// register indexes and reset values for the preemption controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpc_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int DELTA_W     = 10;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_GREEN    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_YELLOW   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OVERRIDE = 2'd2;

    // Reset values of the configuration registers, in milliseconds.
    localparam logic [CFG_DATA_W-1:0] GREEN_RESET    = 16'd6000;
    localparam logic [CFG_DATA_W-1:0] YELLOW_RESET   = 16'd2000;
    localparam logic [CFG_DATA_W-1:0] OVERRIDE_RESET = 16'd4000;

    // Light codes.
    localparam logic [1:0] LAMP_RED    = 2'd0;
    localparam logic [1:0] LAMP_YELLOW = 2'd1;
    localparam logic [1:0] LAMP_GREEN  = 2'd2;

    // Normal-cycle phases.
    localparam logic [1:0] PHASE_V_GREEN  = 2'd0;
    localparam logic [1:0] PHASE_V_YELLOW = 2'd1;
    localparam logic [1:0] PHASE_H_GREEN  = 2'd2;
    localparam logic [1:0] PHASE_H_YELLOW = 2'd3;

    // Request kinds.
    localparam logic FUNC_TICK      = 1'b0;
    localparam logic FUNC_EMERGENCY = 1'b1;

    typedef struct packed {
        logic               func;
        logic [DELTA_W-1:0] delta_ms;
        logic [1:0]         emergency_dir;
    } req_t;

    typedef struct packed {
        logic [1:0] vertical_light;
        logic [1:0] horizontal_light;
        logic       override_active;
        logic [1:0] current_phase;
    } rsp_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] green_time_ms;
        logic [CFG_DATA_W-1:0] yellow_time_ms;
        logic [CFG_DATA_W-1:0] override_time_ms;
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/tlpc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tlpc_cfg_regs: configuration register file
// Holds the green, yellow and override durations written over the
// configuration channel. Writes to an unused index are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpc_cfg_regs
    import tlpc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GREEN:    cfg_next.green_time_ms    = cfg_data;
                CFG_YELLOW:   cfg_next.yellow_time_ms   = cfg_data;
                CFG_OVERRIDE: cfg_next.override_time_ms = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.green_time_ms    <= GREEN_RESET;
            cfg_reg.yellow_time_ms   <= YELLOW_RESET;
            cfg_reg.override_time_ms <= OVERRIDE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tlpc_step.sv @@
// ----------------------------------------------------------------------------
// tlpc_step: next-state logic for one request
// One saturating adder shared by the phase timer and the override timer,
// one limit compare, and the phase sequencing and light forcing.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpc_step
    import tlpc_pkg::*;
#(
    parameter int TIMER_BITS = 17
)
(
    input  wire req_t             req,
    input  wire cfg_t             cfg,
    input  wire logic [1:0]       phase,
    input  wire logic [TIMER_BITS-1:0] phase_timer,
    input  wire logic [1:0]       v_light,
    input  wire logic [1:0]       h_light,
    input  wire logic             ovr_flag,
    input  wire logic [TIMER_BITS-1:0] ovr_timer,
    output logic [1:0]            phase_next,
    output logic [TIMER_BITS-1:0] phase_timer_next,
    output logic [1:0]            v_light_next,
    output logic [1:0]            h_light_next,
    output logic                  ovr_flag_next,
    output logic [TIMER_BITS-1:0] ovr_timer_next,
    output rsp_t                  rsp
);

    localparam int CMP_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;

    logic [TIMER_BITS-1:0] timer_sel;
    logic [TIMER_BITS:0]   sum_full;
    logic [TIMER_BITS-1:0] sum_sat;
    logic [CFG_DATA_W-1:0] limit;
    logic                  expired;

    // The override timer runs instead of the phase timer while the window is open.
    assign timer_sel = ovr_flag ? ovr_timer : phase_timer;
    assign sum_full  = {1'b0, timer_sel} + (TIMER_BITS + 1)'(req.delta_ms);
    assign sum_sat   = sum_full[TIMER_BITS] ? {TIMER_BITS{1'b1}}
                                            : sum_full[TIMER_BITS-1:0];

    always_comb
    begin
        if (ovr_flag)
            limit = cfg.override_time_ms;
        else if (phase[0])
            limit = cfg.yellow_time_ms;
        else
            limit = cfg.green_time_ms;
    end

    assign expired = CMP_W'(sum_sat) > CMP_W'(limit);

    always_comb
    begin
        phase_next       = phase;
        phase_timer_next = phase_timer;
        v_light_next     = v_light;
        h_light_next     = h_light;
        ovr_flag_next    = ovr_flag;
        ovr_timer_next   = ovr_timer;

        if (req.func == FUNC_EMERGENCY)
        begin
            ovr_flag_next  = 1'b1;
            ovr_timer_next = '0;
            // North and south share the vertical road.
            if (!req.emergency_dir[1])
            begin
                v_light_next = LAMP_GREEN;
                h_light_next = LAMP_RED;
            end
            else
            begin
                v_light_next = LAMP_RED;
                h_light_next = LAMP_GREEN;
            end
        end
        else if (ovr_flag)
        begin
            if (expired)
            begin
                ovr_flag_next  = 1'b0;
                ovr_timer_next = '0;
            end
            else
            begin
                ovr_timer_next = sum_sat;
            end
        end
        else if (expired)
        begin
            phase_timer_next = '0;
            case (phase)
                PHASE_V_GREEN:
                begin
                    v_light_next = LAMP_YELLOW;
                    phase_next   = PHASE_V_YELLOW;
                end
                PHASE_V_YELLOW:
                begin
                    v_light_next = LAMP_RED;
                    h_light_next = LAMP_GREEN;
                    phase_next   = PHASE_H_GREEN;
                end
                PHASE_H_GREEN:
                begin
                    h_light_next = LAMP_YELLOW;
                    phase_next   = PHASE_H_YELLOW;
                end
                default:
                begin
                    h_light_next = LAMP_RED;
                    v_light_next = LAMP_GREEN;
                    phase_next   = PHASE_V_GREEN;
                end
            endcase
        end
        else
        begin
            phase_timer_next = sum_sat;
        end
    end

    assign rsp.vertical_light   = v_light_next;
    assign rsp.horizontal_light = h_light_next;
    assign rsp.override_active  = ovr_flag_next;
    assign rsp.current_phase    = phase_next;

endmodule

`default_nettype wire

@@ rtl/core/traffic_light_preemption_controller.sv @@
// ----------------------------------------------------------------------------
// traffic_light_preemption_controller: two-road signal controller
// Normal four-phase cycle with emergency preemption and an override window.
// ----------------------------------------------------------------------------
// The controller takes one request per clock while results are taken, and
// returns one result for each request, carrying the lights, the override
// flag and the phase as they stand after that request. A request is
// captured in an input register; the next-state logic (one saturating add
// and one compare) then updates the controller state and loads the result
// register once the result register can take the result. The input
// register can take a request while a result waits, and a stalled result
// holds the request in the input register until the result is taken.
// Durations are written over the configuration channel, which is always
// ready: index 0 green, 1 yellow, 2 override, all in milliseconds; a write to
// index 3 is ignored. Configuration should change only when no request is in
// flight. TIMER_BITS sets the width of the phase and override timers, which
// saturate at their all-ones value.
// ----------------------------------------------------------------------------
`default_nettype none

module traffic_light_preemption_controller
    import tlpc_pkg::*;
#(
    parameter int TIMER_BITS = 17
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_ready,
    input  wire req_t                   req_data,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    output rsp_t                        rsp_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg;

    // Input stage.
    logic req_valid_reg;
    logic req_valid_next;
    req_t req_data_reg;

    // Result stage.
    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_data_reg;
    rsp_t rsp_comb;

    // Controller state.
    logic [1:0]            phase_reg;
    logic [1:0]            phase_next;
    logic [TIMER_BITS-1:0] phase_timer_reg;
    logic [TIMER_BITS-1:0] phase_timer_next;
    logic [1:0]            v_light_reg;
    logic [1:0]            v_light_next;
    logic [1:0]            h_light_reg;
    logic [1:0]            h_light_next;
    logic                  ovr_flag_reg;
    logic                  ovr_flag_next;
    logic [TIMER_BITS-1:0] ovr_timer_reg;
    logic [TIMER_BITS-1:0] ovr_timer_next;

    logic advance;

    tlpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tlpc_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .req              (req_data_reg),
        .cfg              (cfg),
        .phase            (phase_reg),
        .phase_timer      (phase_timer_reg),
        .v_light          (v_light_reg),
        .h_light          (h_light_reg),
        .ovr_flag         (ovr_flag_reg),
        .ovr_timer        (ovr_timer_reg),
        .phase_next       (phase_next),
        .phase_timer_next (phase_timer_next),
        .v_light_next     (v_light_next),
        .h_light_next     (h_light_next),
        .ovr_flag_next    (ovr_flag_next),
        .ovr_timer_next   (ovr_timer_next),
        .rsp              (rsp_comb)
    );

    // The held request is processed when the result register can take its result.
    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || advance;

    assign req_valid_next = req_ready ? req_valid : req_valid_reg;
    assign rsp_valid_next = advance || (rsp_valid_reg && !rsp_ready);

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg   <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            phase_reg       <= PHASE_V_GREEN;
            phase_timer_reg <= '0;
            v_light_reg     <= LAMP_GREEN;
            h_light_reg     <= LAMP_RED;
            ovr_flag_reg    <= 1'b0;
            ovr_timer_reg   <= '0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (advance)
            begin
                phase_reg       <= phase_next;
                phase_timer_reg <= phase_timer_next;
                v_light_reg     <= v_light_next;
                h_light_reg     <= h_light_next;
                ovr_flag_reg    <= ovr_flag_next;
                ovr_timer_reg   <= ovr_timer_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            req_data_reg <= req_data;
        if (advance)
            rsp_data_reg <= rsp_comb;
    end

endmodule

`default_nettype wire

@@ test/tlpc_checker.sv @@
// ----------------------------------------------------------------------------
// tlpc_checker: result checker for the preemption controller
// Watches the request, result and configuration channels, predicts the
// lights, override flag and phase after every accepted request, and compares
// each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tlpc_checker
    import tlpc_pkg::*;
#(
    parameter int TIMER_W = 17
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic                   req_ready,
    input  req_t                   req_data,
    input  logic                   rsp_valid,
    input  logic                   rsp_ready,
    input  rsp_t                   rsp_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatch_count,
    output int                     pending_count
);

    typedef struct packed {
        logic [1:0]         phase;
        logic [TIMER_W-1:0] phase_ms;
        logic [1:0]         vertical;
        logic [1:0]         horizontal;
        logic               override_on;
        logic [TIMER_W-1:0] override_ms;
    } signal_state_t;

    signal_state_t signals;
    cfg_t          durations;
    rsp_t          expected_lights[$];

    function automatic logic [TIMER_W-1:0] sat_add_ms(input logic [TIMER_W-1:0] t,
                                                      input logic [DELTA_W-1:0] d);
        logic [TIMER_W:0] sum;
        sum = {1'b0, t} + d;
        return sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
    endfunction

    function automatic signal_state_t step_signals(input signal_state_t s, input req_t r,
                                                   input cfg_t c);
        signal_state_t         n;
        logic [CFG_DATA_W-1:0] limit;
        n = s;
        if (r.func == FUNC_EMERGENCY)
        begin
            n.override_on = 1'b1;
            n.override_ms = '0;
            // North and south have the upper direction bit clear.
            if (!r.emergency_dir[1])
            begin
                n.vertical   = LAMP_GREEN;
                n.horizontal = LAMP_RED;
            end
            else
            begin
                n.horizontal = LAMP_GREEN;
                n.vertical   = LAMP_RED;
            end
        end
        else if (s.override_on)
        begin
            n.override_ms = sat_add_ms(s.override_ms, r.delta_ms);
            if (n.override_ms > c.override_time_ms)
            begin
                n.override_on = 1'b0;
                n.override_ms = '0;
            end
        end
        else
        begin
            n.phase_ms = sat_add_ms(s.phase_ms, r.delta_ms);
            limit = s.phase[0] ? c.yellow_time_ms : c.green_time_ms;
            if (n.phase_ms > limit)
            begin
                n.phase_ms = '0;
                // Each change sets only the lights that it names.
                case (s.phase)
                    PHASE_V_GREEN:
                    begin
                        n.vertical = LAMP_YELLOW;
                        n.phase    = PHASE_V_YELLOW;
                    end
                    PHASE_V_YELLOW:
                    begin
                        n.vertical   = LAMP_RED;
                        n.horizontal = LAMP_GREEN;
                        n.phase      = PHASE_H_GREEN;
                    end
                    PHASE_H_GREEN:
                    begin
                        n.horizontal = LAMP_YELLOW;
                        n.phase      = PHASE_H_YELLOW;
                    end
                    default:
                    begin
                        n.horizontal = LAMP_RED;
                        n.vertical   = LAMP_GREEN;
                        n.phase      = PHASE_V_GREEN;
                    end
                endcase
            end
        end
        return n;
    endfunction

    task automatic check_field(input string name, input logic [1:0] want,
                               input logic [1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        int   delta;
        if (!rst_n)
        begin
            signals = '{phase: PHASE_V_GREEN, phase_ms: '0, vertical: LAMP_GREEN,
                        horizontal: LAMP_RED, override_on: 1'b0, override_ms: '0};
            durations = '{GREEN_RESET, YELLOW_RESET, OVERRIDE_RESET};
            expected_lights.delete();
            mismatch_count = 0;
            pending_count <= 0;
        end
        else
        begin
            delta = 0;
            if (rsp_valid && rsp_ready)
            begin
                delta = delta - 1;
                if (expected_lights.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, rsp_data);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_lights.pop_front();
                    check_field("vertical_light", want.vertical_light,
                                rsp_data.vertical_light);
                    check_field("horizontal_light", want.horizontal_light,
                                rsp_data.horizontal_light);
                    check_field("override_active", 2'(want.override_active),
                                2'(rsp_data.override_active));
                    check_field("current_phase", want.current_phase,
                                rsp_data.current_phase);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GREEN:    durations.green_time_ms    = cfg_data;
                    CFG_YELLOW:   durations.yellow_time_ms   = cfg_data;
                    CFG_OVERRIDE: durations.override_time_ms = cfg_data;
                    default:      ;
                endcase
            end
            if (req_valid && req_ready)
            begin
                delta = delta + 1;
                signals = step_signals(signals, req_data, durations);
                want.vertical_light   = signals.vertical;
                want.horizontal_light = signals.horizontal;
                want.override_active  = signals.override_on;
                want.current_phase    = signals.phase;
                expected_lights.push_back(want);
            end
            pending_count <= pending_count + delta;
        end
    end

endmodule

@@ test/traffic_light_preemption_controller_test.sv @@
// ----------------------------------------------------------------------------
// traffic_light_preemption_controller_test: top-level testbench
// Drives a directed opening and several randomized phases of ticks and
// emergency requests through the controller, under changing durations and
// pacing, while a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module traffic_light_preemption_controller_test
    import tlpc_pkg::*;
();

    localparam int TIMER_W         = 17;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 166;
    // Quiet time after the last result is back, before reconfiguring or
    // finishing, leaves room to spare.
    localparam int SETTLE_CYCLES   = 4;

    // Index 3 is not a register; the controller must ignore a write to it.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [1:0] TO_NORTH = 2'd0;
    localparam logic [1:0] TO_SOUTH = 2'd1;
    localparam logic [1:0] TO_EAST  = 2'd2;
    localparam logic [1:0] TO_WEST  = 2'd3;

    localparam logic [DELTA_W-1:0]    DELTA_MAX    = '1;
    localparam logic [CFG_DATA_W-1:0] DURATION_MAX = '1;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    req_t                   req_data  = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b1;
    rsp_t                   rsp_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int mismatch_count;
    int pending_count;

    // Pacing knobs, in percent of cycles.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    int requests_sent    = 0;
    int emergencies_sent = 0;

    traffic_light_preemption_controller #(.TIMER_BITS(TIMER_W)) dut (.*);

    tlpc_checker #(.TIMER_W(TIMER_W)) u_checker (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    // The result side stalls at random according to the current phase.
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Hard stop in case the controller hangs; far beyond the slowest run.
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Presents one request and returns at the edge where it is accepted.
    // Valid stays high on return so that back-to-back requests never lower
    // and raise it in the same step; it is lowered only when the sender idles
    // or drains.
    task automatic send_item(input logic func, input logic [DELTA_W-1:0] delta,
                             input logic [1:0] dir);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid              <= 1'b1;
        req_data.func          <= func;
        req_data.delta_ms      <= delta;
        req_data.emergency_dir <= dir;
        do
            @(posedge clk);
        while (!req_ready);
        requests_sent++;
        if (func == FUNC_EMERGENCY)
            emergencies_sent++;
    endtask

    // Stops sending and waits until every predicted result has arrived.
    // The first edge lets the checker count the last accepted request.
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Writes all three durations back to back, then releases the channel.
    task automatic apply_durations(input logic [CFG_DATA_W-1:0] green,
                                   input logic [CFG_DATA_W-1:0] yellow,
                                   input logic [CFG_DATA_W-1:0] window);
        cfg_write(CFG_GREEN, green);
        cfg_write(CFG_YELLOW, yellow);
        cfg_write(CFG_OVERRIDE, window);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [DELTA_W-1:0] delta;
        int                 pick;
        int                 emergency_pct;
        bit                 long_steps;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under the reset durations (6000, 2000, 4000 ms).
        // A zero tick changes nothing, then six full-scale ticks cross the
        // green time and move to vertical yellow.
        send_item(FUNC_TICK, '0, TO_NORTH);
        repeat (6) send_item(FUNC_TICK, DELTA_MAX, TO_NORTH);
        // An east emergency forces horizontal green and opens the window;
        // ticks now only run the override timer.
        send_item(FUNC_EMERGENCY, DELTA_MAX, TO_EAST);
        repeat (3) send_item(FUNC_TICK, DELTA_MAX, TO_WEST);
        // A second emergency inside the window restarts it and forces the
        // lights again, this time toward north.
        send_item(FUNC_EMERGENCY, '0, TO_NORTH);
        // Four ticks pass the window length; the window closes on the last
        // one without moving the phase.
        repeat (4) send_item(FUNC_TICK, DELTA_MAX, TO_SOUTH);
        // The forced lights stay until the held yellow phase runs out.
        repeat (2) send_item(FUNC_TICK, DELTA_MAX, TO_EAST);
        send_item(FUNC_EMERGENCY, DELTA_MAX, TO_SOUTH);
        send_item(FUNC_EMERGENCY, '0, TO_WEST);
        drain_results();

        // Zero durations: a zero tick never advances, a one-millisecond tick
        // does, and a zero window closes only on a nonzero tick.
        apply_durations('0, '0, '0);
        send_item(FUNC_TICK, '0, TO_NORTH);
        send_item(FUNC_TICK, 10'd1, TO_NORTH);
        send_item(FUNC_EMERGENCY, 10'd1, TO_EAST);
        send_item(FUNC_TICK, '0, TO_EAST);
        send_item(FUNC_TICK, 10'd1, TO_WEST);
        drain_results();

        // Randomized phases. Each one sets new durations while idle, picks
        // a pacing mode, and pauses halfway until all results are back.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            emergency_pct = 8;
            long_steps    = 1'b0;
            case (phase)
                1:
                begin
                    apply_durations('0, '0, '0);
                    cfg_write(CFG_SPARE, DURATION_MAX);
                    cfg_valid <= 1'b0;
                end
                2:
                begin
                    // Longest durations: few emergencies and long ticks, so
                    // the phases still move within the phase.
                    apply_durations(DURATION_MAX, DURATION_MAX, DURATION_MAX);
                    emergency_pct = 2;
                    long_steps    = 1'b1;
                end
                7:
                    apply_durations(GREEN_RESET, YELLOW_RESET, OVERRIDE_RESET);
                default:
                    apply_durations(CFG_DATA_W'($urandom_range(0, 3000)),
                                    CFG_DATA_W'($urandom_range(0, 1500)),
                                    CFG_DATA_W'($urandom_range(0, 2500)));
            endcase

            case (phase % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 86;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 86;
                end
                default:
                begin
                    sender_idle_pct    = 35;
                    receiver_stall_pct = 35;
                end
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == ITEMS_PER_PHASE / 2)
                    drain_results();
                // Tick lengths lean toward the extremes and toward short
                // steps that land close to the phase boundaries.
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    delta = '0;
                else if (pick < 12 || (long_steps && pick < 70))
                    delta = DELTA_MAX;
                else if (pick < 40)
                    delta = DELTA_W'($urandom_range(0, 63));
                else
                    delta = DELTA_W'($urandom_range(0, DELTA_MAX));
                if ($urandom_range(0, 99) < emergency_pct)
                    send_item(FUNC_EMERGENCY, delta, 2'($urandom_range(0, 3)));
                else
                    send_item(FUNC_TICK, delta, 2'($urandom_range(0, 3)));
            end
            drain_results();
        end

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;

        $display("Run covered %0d requests, %0d of them emergencies, across %0d random phases",
                 requests_sent, emergencies_sent, RANDOM_PHASES);
        $display("with zero, full-scale and random durations and four pacing modes.");
        if (mismatch_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
